// ===== hw/rtl/nhph_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nhph_pkg;

  // Key layout
  localparam int unsigned LAST_BYTES  = 4;
  localparam int unsigned FIRST_BYTES = 2;
  localparam int unsigned NUM_LANES   = LAST_BYTES + FIRST_BYTES;
  localparam logic [7:0]  PAD_BYTE    = 8'h5F;

  // Datapath widths
  localparam int unsigned HASH_W = 64;
  localparam int unsigned BASE_W = 31;
  localparam int unsigned BKT_W  = 16;

  // Remainder pipeline: bits of the dividend consumed per stage
  localparam int unsigned MOD_BITS   = 4;
  localparam int unsigned MOD_STAGES = HASH_W / MOD_BITS;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = BASE_W;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(31);
  localparam logic [BKT_W-1:0]  BKT_RESET  = BKT_W'(101);

  typedef logic [HASH_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_BASE    = 1'b0,
    REG_BUCKET_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    POW_IDLE,
    POW_LO,
    POW_HI
  } pow_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nhph_key_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nhph_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] last_char_0;
  logic [7:0] last_char_1;
  logic [7:0] last_char_2;
  logic [7:0] last_char_3;
  logic [7:0] first_char_0;
  logic [7:0] first_char_1;

  modport source (
    output valid, last_char_0, last_char_1, last_char_2, last_char_3,
           first_char_0, first_char_1,
    input  ready
  );

  modport sink (
    input  valid, last_char_0, last_char_1, last_char_2, last_char_3,
           first_char_0, first_char_1,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nhph_idx_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface nhph_idx_if;
  logic                       valid;
  logic                       ready;
  logic [nhph_pkg::BKT_W-1:0] bucket_index;

  modport source (
    output valid, bucket_index,
    input  ready
  );

  modport sink (
    input  valid, bucket_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/nhph_pow.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Power table: base^k mod 2^64 for k = 0 .. NUM_LANES-1, rebuilt by a
// sequencer after reset and after each base write. Each power is built in
// POW_LO (low-half partial product), then POW_HI (high-half partial product and add).
module nhph_pow (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        restart,
  input  wire logic [nhph_pkg::BASE_W-1:0]                 base,
  output nhph_pkg::word_t [nhph_pkg::NUM_LANES-1:0]        pow,
  output logic                                             busy
);

  localparam int unsigned IDX_W  = $clog2(nhph_pkg::NUM_LANES);
  localparam int unsigned HALF_W = nhph_pkg::HASH_W / 2;
  localparam int unsigned PROD_W = HALF_W + nhph_pkg::BASE_W;

  nhph_pkg::pow_state_t state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  nhph_pkg::word_t      cur_r, cur_nxt;
  logic [PROD_W-1:0]    lo_r, lo_nxt;
  logic [PROD_W-1:0]    hi_prod;
  nhph_pkg::word_t      pw_new;
  nhph_pkg::word_t      pw_r [nhph_pkg::NUM_LANES-1:1];

  // Next power from the running one
  always_comb begin
    hi_prod = PROD_W'(cur_r[nhph_pkg::HASH_W-1:HALF_W]) * PROD_W'(base);
    pw_new  = nhph_pkg::HASH_W'(lo_r) + {hi_prod[HALF_W-1:0], HALF_W'(0)};
  end

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    lo_nxt    = lo_r;
    unique case (state_r)
      nhph_pkg::POW_IDLE: begin
      end
      nhph_pkg::POW_LO: begin
        lo_nxt    = PROD_W'(cur_r[HALF_W-1:0]) * PROD_W'(base);
        state_nxt = nhph_pkg::POW_HI;
      end
      nhph_pkg::POW_HI: begin
        cur_nxt = pw_new;
        if (idx_r == IDX_W'(nhph_pkg::NUM_LANES - 1)) begin
          state_nxt = nhph_pkg::POW_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = nhph_pkg::POW_LO;
        end
      end
      default: state_nxt = nhph_pkg::POW_IDLE;
    endcase
    if (restart) begin
      state_nxt = nhph_pkg::POW_LO;
      idx_nxt   = IDX_W'(1);
      cur_nxt   = nhph_pkg::HASH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nhph_pkg::POW_LO;
      idx_r   <= IDX_W'(1);
      cur_r   <= nhph_pkg::HASH_W'(1);
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // Hold partial product and table entries
  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    if (state_r == nhph_pkg::POW_HI) begin
      pw_r[idx_r] <= pw_new;
    end
  end

  // Drive table outputs
  always_comb begin
    pow[0] = nhph_pkg::HASH_W'(1);
    for (int k = 1; k < nhph_pkg::NUM_LANES; k++) begin
      pow[k] = pw_r[k];
    end
  end

  assign busy = (state_r != nhph_pkg::POW_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/nhph_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One lane: signed byte times its positional power, mod 2^64, registered.
module nhph_lane (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [7:0]      char_byte,
  input  wire nhph_pkg::word_t power,
  output nhph_pkg::word_t      prod
);

  nhph_pkg::word_t mag;
  nhph_pkg::word_t neg_adj;
  nhph_pkg::word_t prod_r, prod_nxt;

  // Unsigned product, then remove 256*power for a negative byte
  always_comb begin
    mag      = nhph_pkg::HASH_W'(char_byte) * power;
    neg_adj  = char_byte[7] ? {power[nhph_pkg::HASH_W-9:0], 8'd0} : '0;
    prod_nxt = mag - neg_adj;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nhph_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Merge stage: registered three-level adder tree over the six lane products.
module nhph_sum (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire nhph_pkg::word_t [nhph_pkg::NUM_LANES-1:0] terms,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output nhph_pkg::word_t                                total
);

  localparam int unsigned PAIRS = nhph_pkg::NUM_LANES / 2;

  logic [2:0]      vld_r;
  logic [2:0]      en;
  nhph_pkg::word_t s1_r [PAIRS];
  nhph_pkg::word_t s2_r [2];
  nhph_pkg::word_t s3_r;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[2] = !vld_r[2] || out_ready;
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  // Pairwise sums, then fold the three partials
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < PAIRS; j++) begin
        s1_r[j] <= terms[2*j] + terms[2*j+1];
      end
    end
    if (en[1]) begin
      s2_r[0] <= s1_r[0] + s1_r[1];
      s2_r[1] <= s1_r[2];
    end
    if (en[2]) begin
      s3_r <= s2_r[0] + s2_r[1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[2];
  assign total     = s3_r;

endmodule

`default_nettype wire

// ===== hw/rtl/nhph_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring remainder: 64-bit dividend by a 16-bit divisor,
// MOD_BITS dividend bits per stage. Divisor must be nonzero for a
// meaningful remainder; the caller masks the zero case.
module nhph_mod (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire nhph_pkg::word_t               dividend,
  input  wire logic [nhph_pkg::BKT_W-1:0]    divisor,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [nhph_pkg::BKT_W-1:0]         remainder
);

  localparam int unsigned S     = nhph_pkg::MOD_STAGES;
  localparam int unsigned MB    = nhph_pkg::MOD_BITS;
  localparam int unsigned W     = nhph_pkg::HASH_W;
  localparam int unsigned BW    = nhph_pkg::BKT_W;

  // Shift in MB bits, one compare-and-subtract each
  function automatic logic [BW-1:0] mod_step(
    input logic [BW-1:0] rem_in,
    input logic [MB-1:0] bits,
    input logic [BW-1:0] d
  );
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = rem_in;
    for (int b = MB - 1; b >= 0; b--) begin
      t = {r, bits[b]};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
      end
      r = t[BW-1:0];
    end
    return r;
  endfunction

  logic [S-1:0]    vld_r;
  logic [S-1:0]    vld_src;
  logic [S-1:0]    en;
  logic [BW-1:0]   rem_r   [S];
  logic [BW-1:0]   rem_src [S];
  logic [BW-1:0]   rem_nxt [S];
  nhph_pkg::word_t quo_r   [S];
  nhph_pkg::word_t quo_src [S];
  nhph_pkg::word_t quo_nxt [S];

  // Stage inputs
  always_comb begin
    vld_src[0] = in_valid;
    rem_src[0] = '0;
    quo_src[0] = dividend;
    for (int i = 1; i < S; i++) begin
      vld_src[i] = vld_r[i-1];
      rem_src[i] = rem_r[i-1];
      quo_src[i] = quo_r[i-1];
    end
  end

  // Stage arithmetic
  always_comb begin
    for (int i = 0; i < S; i++) begin
      rem_nxt[i] = mod_step(rem_src[i], quo_src[i][W-1:W-MB], divisor);
      quo_nxt[i] = quo_src[i] << MB;
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[S-1] = !vld_r[S-1] || out_ready;
    for (int i = S - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < S; i++) begin
        if (en[i]) vld_r[i] <= vld_src[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < S; i++) begin
      if (en[i]) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[S-1];
  assign remainder = rem_r[S-1];

endmodule

`default_nettype wire

// ===== hw/rtl/name_key_polynomial_hash_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Stages: 1 lane multiply stage, 3 adder-tree stages, 16 remainder stages of
// 4 bits each. Throughput: one key per cycle unless the power table is
// rebuilding; stages hold and fill bubbles under stall.
// Reset (synchronous, rst_n low) clears all valids, sets hash_base to 31 and
// bucket_count to 101; the power table then rebuilds, as it does after every
// hash_base write, with in_key.ready low meanwhile.
module name_key_polynomial_hash_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  nhph_key_if.sink                              in_key,
  nhph_idx_if.source                            out_idx,
  input  wire logic                             cfg_we,
  input  wire logic [nhph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nhph_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned NL = nhph_pkg::NUM_LANES;

  logic [nhph_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [nhph_pkg::BKT_W-1:0]  bkt_r, bkt_nxt;
  logic                        pow_restart;
  logic                        pow_busy;
  nhph_pkg::word_t [NL-1:0]    pow;
  logic [7:0]                  raw_byte [NL];
  logic [7:0]                  pad_byte [NL];
  logic                        ended;
  logic                        lane_vld_r;
  logic                        lane_en;
  logic                        accept;
  nhph_pkg::word_t [NL-1:0]    lane_prod;
  logic                        sum_in_ready;
  logic                        sum_out_valid;
  nhph_pkg::word_t             sum_total;
  logic                        mod_in_ready;
  logic                        mod_out_valid;
  logic [nhph_pkg::BKT_W-1:0]  mod_rem;

  // Decode configuration writes
  always_comb begin
    base_nxt = base_r;
    bkt_nxt  = bkt_r;
    if (cfg_we) begin
      unique case (nhph_pkg::cfg_reg_t'(cfg_index))
        nhph_pkg::REG_HASH_BASE:    base_nxt = cfg_data[nhph_pkg::BASE_W-1:0];
        nhph_pkg::REG_BUCKET_COUNT: bkt_nxt  = cfg_data[nhph_pkg::BKT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= nhph_pkg::BASE_RESET;
      bkt_r  <= nhph_pkg::BKT_RESET;
    end else begin
      base_r <= base_nxt;
      bkt_r  <= bkt_nxt;
    end
  end

  assign pow_restart = cfg_we && (cfg_index == nhph_pkg::REG_HASH_BASE);

  nhph_pow u_pow (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (pow_restart),
    .base    (base_r),
    .pow     (pow),
    .busy    (pow_busy)
  );

  // Pad each name from its first zero byte on
  always_comb begin
    raw_byte[0] = in_key.last_char_0;
    raw_byte[1] = in_key.last_char_1;
    raw_byte[2] = in_key.last_char_2;
    raw_byte[3] = in_key.last_char_3;
    raw_byte[4] = in_key.first_char_0;
    raw_byte[5] = in_key.first_char_1;
    ended = 1'b0;
    for (int k = 0; k < nhph_pkg::LAST_BYTES; k++) begin
      ended       = ended || (raw_byte[k] == 8'd0);
      pad_byte[k] = ended ? nhph_pkg::PAD_BYTE : raw_byte[k];
    end
    ended = 1'b0;
    for (int k = nhph_pkg::LAST_BYTES; k < NL; k++) begin
      ended       = ended || (raw_byte[k] == 8'd0);
      pad_byte[k] = ended ? nhph_pkg::PAD_BYTE : raw_byte[k];
    end
  end

  // Lane stage handshake
  assign lane_en       = !lane_vld_r || sum_in_ready;
  assign in_key.ready  = lane_en && !pow_busy;
  assign accept        = in_key.valid && in_key.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= 1'b0;
    end else if (lane_en) begin
      lane_vld_r <= accept;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    nhph_lane u_lane (
      .clk       (clk),
      .en        (lane_en),
      .char_byte (pad_byte[g]),
      .power     (pow[g]),
      .prod      (lane_prod[g])
    );
  end

  nhph_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lane_vld_r),
    .in_ready  (sum_in_ready),
    .terms     (lane_prod),
    .out_valid (sum_out_valid),
    .out_ready (mod_in_ready),
    .total     (sum_total)
  );

  nhph_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_out_valid),
    .in_ready  (mod_in_ready),
    .dividend  (sum_total),
    .divisor   (bkt_r),
    .out_valid (mod_out_valid),
    .out_ready (out_idx.ready),
    .remainder (mod_rem)
  );

  // Zero bucket count maps every key to bucket zero
  assign out_idx.valid        = mod_out_valid;
  assign out_idx.bucket_index = (bkt_r == '0) ? '0 : mod_rem;

  // An accepted transaction occupies the lane stage next cycle
  a_accept_fills_lane: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> lane_vld_r)
    else $error("accepted transaction missing from lane stage");

  // A base write rebuilds the power table before the next key
  a_base_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pow_restart |=> (pow_busy && !in_key.ready))
    else $error("power table not rebuilding after base write");

  // Keys are never taken while the power table is stale
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pow_busy |-> !accept)
    else $error("transaction accepted during power table rebuild");

endmodule

`default_nettype wire

// ===== verif/name_key_polynomial_hash_unit_test.sv =====
`timescale 1ns / 1ps

module name_key_polynomial_hash_unit_test;

  typedef logic [nhph_pkg::NUM_LANES-1:0][7:0] name_key_t;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned ROUNDS      = 10;
  localparam int unsigned ROUND_KEYS  = 55;
  localparam int unsigned STALL_LEN   = 300;
  localparam int unsigned DRAIN_WAIT  = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Sender side
  logic      key_vld = 1'b0;
  name_key_t key_cur = '0;

  // Receiver side
  logic idx_rdy = 1'b0;

  // Register write port
  logic                            cfg_we  = 1'b0;
  nhph_pkg::cfg_reg_t              cfg_sel = nhph_pkg::REG_HASH_BASE;
  logic [nhph_pkg::CFG_DATA_W-1:0] cfg_val = '0;

  // Local copy of the register file
  logic [nhph_pkg::BASE_W-1:0] model_base  = nhph_pkg::BASE_RESET;
  logic [nhph_pkg::BKT_W-1:0]  model_count = nhph_pkg::BKT_RESET;

  name_key_t                  key_backlog[$];
  logic [nhph_pkg::BKT_W-1:0] due_buckets[$];
  int                         keys_queued    = 0;
  int                         keys_taken     = 0;
  int                         mismatch_count = 0;
  int unsigned                cycle_count    = 0;
  int unsigned                send_idle_pct  = 0;
  int unsigned                recv_idle_pct  = 0;

  // Long receiver hold-off
  logic        stall_go   = 1'b0;
  logic        stall_done = 1'b0;
  int unsigned stall_left = 0;

  nhph_key_if key_bus ();
  nhph_idx_if idx_bus ();

  assign key_bus.valid        = key_vld;
  assign key_bus.last_char_0  = key_cur[0];
  assign key_bus.last_char_1  = key_cur[1];
  assign key_bus.last_char_2  = key_cur[2];
  assign key_bus.last_char_3  = key_cur[3];
  assign key_bus.first_char_0 = key_cur[4];
  assign key_bus.first_char_1 = key_cur[5];
  assign idx_bus.ready        = idx_rdy;

  name_key_polynomial_hash_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_key    (key_bus),
    .out_idx   (idx_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_sel),
    .cfg_data  (cfg_val)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Weighted byte sum of the padded key, reduced to a bucket
  function automatic logic [nhph_pkg::BKT_W-1:0] hash_bucket(
    name_key_t key, logic [nhph_pkg::BASE_W-1:0] base, logic [nhph_pkg::BKT_W-1:0] buckets);
    nhph_pkg::word_t weight;
    nhph_pkg::word_t total;
    logic [7:0]      ch;
    logic            ended;
    weight = nhph_pkg::word_t'(1);
    total  = '0;
    ended  = 1'b0;
    for (int lane = 0; lane < nhph_pkg::NUM_LANES; lane++) begin
      // each name has its own terminator
      if (lane == nhph_pkg::LAST_BYTES) ended = 1'b0;
      ch = key[lane];
      if (ch == 8'h00) ended = 1'b1;
      if (ended) ch = nhph_pkg::PAD_BYTE;
      total  = total + ({{56{ch[7]}}, ch} * weight);
      weight = weight * nhph_pkg::word_t'(base);
    end
    if (buckets == '0) return '0;
    return nhph_pkg::BKT_W'(total % nhph_pkg::word_t'(buckets));
  endfunction

  function automatic name_key_t make_key(logic [7:0] l0, logic [7:0] l1, logic [7:0] l2,
                                         logic [7:0] l3, logic [7:0] f0, logic [7:0] f1);
    return {f1, f0, l3, l2, l1, l0};
  endfunction

  // Mostly name-like keys, some raw noise
  function automatic name_key_t random_key();
    name_key_t   k;
    int unsigned mode;
    int unsigned last_len;
    int unsigned first_len;
    int unsigned len;
    int unsigned pos;
    mode      = $urandom_range(9);
    last_len  = $urandom_range(nhph_pkg::LAST_BYTES);
    first_len = $urandom_range(nhph_pkg::FIRST_BYTES);
    k         = name_key_t'({$urandom, $urandom});
    if (mode < 2) return k;
    for (int lane = 0; lane < nhph_pkg::NUM_LANES; lane++) begin
      len = (lane < nhph_pkg::LAST_BYTES) ? last_len : first_len;
      pos = (lane < nhph_pkg::LAST_BYTES) ? lane : lane - nhph_pkg::LAST_BYTES;
      if (pos < len) begin
        if (mode == 3) k[lane] = 8'($urandom_range(8'h80, 8'hFF));
        else if (mode < 6) k[lane] = 8'($urandom_range("A", "Z"));
        else k[lane] = 8'($urandom_range("a", "z"));
      end else if (pos == len || mode != 2) begin
        k[lane] = 8'h00;
      end
      // mode 2 leaves random bytes behind the terminator
    end
    return k;
  endfunction

  function automatic logic [nhph_pkg::BASE_W-1:0] random_base();
    case ($urandom_range(5))
      0: return nhph_pkg::BASE_W'($urandom_range(1, 64));
      1: return {nhph_pkg::BASE_W{1'b1}};
      2: return '0;
      3: return nhph_pkg::BASE_W'(1);
      default: return nhph_pkg::BASE_W'($urandom);
    endcase
  endfunction

  function automatic logic [nhph_pkg::BKT_W-1:0] random_count();
    case ($urandom_range(6))
      0: return nhph_pkg::BKT_W'($urandom_range(1, 16));
      1: return {nhph_pkg::BKT_W{1'b1}};
      2: return '0;
      3: return nhph_pkg::BKT_W'(1);
      default: return nhph_pkg::BKT_W'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic write_reg(input nhph_pkg::cfg_reg_t which,
                           input logic [nhph_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we  <= 1'b1;
    cfg_sel <= which;
    cfg_val <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == nhph_pkg::REG_HASH_BASE) model_base = value;
    else model_count = value[nhph_pkg::BKT_W-1:0];
  endtask

  task automatic push_key(input name_key_t k);
    key_backlog.push_back(k);
    keys_queued++;
  endtask

  // Hold until every queued key is taken and its bucket has come back
  task automatic settle();
    do @(posedge clk);
    while (keys_taken != keys_queued || due_buckets.size() != 0);
  endtask

  // Driver: offer backlog keys, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      key_vld <= 1'b0;
    end else begin
      if (key_vld && key_bus.ready) begin
        due_buckets.push_back(hash_bucket(key_cur, model_base, model_count));
        keys_taken++;
      end
      if (!key_vld || key_bus.ready) begin
        if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          key_vld <= 1'b1;
          key_cur <= key_backlog.pop_front();
        end else begin
          key_vld <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    logic [nhph_pkg::BKT_W-1:0] want;
    if (!rst_n) begin
      idx_rdy <= 1'b0;
    end else begin
      if (idx_bus.valid && idx_rdy) begin
        if (due_buckets.size() == 0) begin
          $display("%0t: unexpected bucket_index, expected none, actual %0d",
                   $time, idx_bus.bucket_index);
          mismatch_count++;
        end else begin
          want = due_buckets.pop_front();
          if (idx_bus.bucket_index !== want) begin
            $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                     $time, want, idx_bus.bucket_index);
            mismatch_count++;
          end
        end
      end
      idx_rdy <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Count down the one long receiver hold-off
  always @(posedge clk) begin
    if (stall_go && !stall_done) begin
      stall_left <= STALL_LEN;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 49;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed keys at reset settings
    push_key(make_key(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    push_key(make_key(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_key(make_key(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80));
    push_key(make_key(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F));
    push_key(make_key("S", "m", "i", "t", "J", "o"));
    // terminator at each position, junk behind it
    push_key(make_key(8'h00, "A", "B", "C", "D", "E"));
    push_key(make_key("A", 8'h00, "B", 8'hC3, 8'h00, "F"));
    push_key(make_key("A", "B", 8'h00, 8'hFF, "F", 8'h00));
    push_key(make_key("A", "B", "C", 8'h00, "F", 8'h91));
    push_key(make_key(8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F, 8'h5F));
    push_key(make_key(8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
    push_key(make_key(8'hFE, 8'h81, 8'hC0, 8'hA0, 8'h90, 8'h88));
    settle();

    // Zero base: only the first byte carries weight
    write_reg(nhph_pkg::REG_HASH_BASE, '0);
    push_key(make_key(8'hFF, "B", "C", "D", "E", "F"));
    push_key(make_key("Q", 8'h80, 8'h00, "D", 8'h00, "F"));
    settle();

    // Unit base with the widest bucket count
    write_reg(nhph_pkg::REG_HASH_BASE, nhph_pkg::CFG_DATA_W'(1));
    write_reg(nhph_pkg::REG_BUCKET_COUNT, nhph_pkg::CFG_DATA_W'(16'hFFFF));
    push_key(make_key(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    push_key(make_key("W", "a", "r", "d", "E", "d"));
    settle();

    // Widest base
    write_reg(nhph_pkg::REG_HASH_BASE, {nhph_pkg::CFG_DATA_W{1'b1}});
    push_key(make_key(8'h7F, 8'h80, 8'hFF, 8'h01, 8'h7F, 8'h80));
    push_key(make_key("Z", "z", "Z", "z", "Z", "z"));
    settle();

    // Zero bucket count, upper data bits set and dropped
    write_reg(nhph_pkg::REG_BUCKET_COUNT,
              {{(nhph_pkg::CFG_DATA_W-nhph_pkg::BKT_W){1'b1}}, 16'h0000});
    push_key(make_key("L", "e", "e", 8'h00, "A", "n"));
    push_key(make_key(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    settle();

    // Single bucket
    write_reg(nhph_pkg::REG_BUCKET_COUNT, nhph_pkg::CFG_DATA_W'(1));
    push_key(make_key("K", "i", "m", 8'h00, "J", 8'h00));
    settle();

    // Random rounds over changing settings and idle profiles
    for (int unsigned round = 0; round < ROUNDS; round++) begin
      if (round == 4) begin
        send_idle_pct = 49;
        recv_idle_pct = 34;
      end else if (round == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(nhph_pkg::REG_HASH_BASE, random_base());
      write_reg(nhph_pkg::REG_BUCKET_COUNT,
                (nhph_pkg::CFG_DATA_W'($urandom) &
                 {{(nhph_pkg::CFG_DATA_W-nhph_pkg::BKT_W){1'b1}}, {nhph_pkg::BKT_W{1'b0}}}) |
                nhph_pkg::CFG_DATA_W'(random_count()));
      if (round == 7) begin
        // Fill the pipe against a held-off receiver
        for (int unsigned n = 0; n < ROUND_KEYS; n++) push_key(random_key());
        @(posedge clk);
        stall_go <= 1'b1;
      end else if (round % 2 == 1) begin
        // Pause the sender midway until all buckets are back
        for (int unsigned n = 0; n < ROUND_KEYS / 2; n++) push_key(random_key());
        settle();
        for (int unsigned n = ROUND_KEYS / 2; n < ROUND_KEYS; n++) push_key(random_key());
      end else begin
        for (int unsigned n = 0; n < ROUND_KEYS; n++) push_key(random_key());
      end
      settle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (due_buckets.size() != 0) begin
      $display("%0t: %0d bucket_index results missing, expected %0d, actual none",
               $time, due_buckets.size(), due_buckets[0]);
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/nhph_pkg.sv
hw/rtl/nhph_key_if.sv
hw/rtl/nhph_idx_if.sv
hw/rtl/nhph_pow.sv
hw/rtl/nhph_lane.sv
hw/rtl/nhph_sum.sv
hw/rtl/nhph_mod.sv
hw/rtl/name_key_polynomial_hash_unit.sv
verif/name_key_polynomial_hash_unit_test.sv
